@@ sv/pgm_pkg.sv @@
// ============================================================================
// pgm_pkg: shared definitions for the Prewitt gradient magnitude unit
// Sizes, field widths, register indexes and the tag that travels with a
// result through the arithmetic pipeline.
// ============================================================================
package pgm_pkg;

    // Largest frame the line memory and counters are built for.
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;

    // Counter and configuration widths.
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int CFG_W = 12;

    // Field widths of the stream payload.
    localparam int PIX_W = 8;
    localparam int POS_W = 11;
    localparam int MAG_W = 8;

    // Square root datapath: a 2*MAG_W bit radicand gives MAG_W root bits,
    // one bit per pipeline stage.
    localparam int RAD_W       = 2 * MAG_W;
    localparam int REM_W       = MAG_W + 2;
    localparam int SQRT_STAGES = MAG_W;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    // Information that rides along with a result.
    typedef struct packed {
        logic             sat;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic             last;
    } pgm_tag_t;

endpackage

@@ sv/pgm_isqrt.sv @@
// ============================================================================
// pgm_isqrt: pipelined integer square root
// Restoring digit recurrence, one root bit per stage, with a valid/ready
// chain so that any stage can hold while the output is stalled.
// ============================================================================
module pgm_isqrt
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [pgm_pkg::RAD_W-1:0]    in_rad,
    input  pgm_pkg::pgm_tag_t            in_tag,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [pgm_pkg::MAG_W-1:0]    out_root,
    output pgm_pkg::pgm_tag_t            out_tag
);

    localparam int N = pgm_pkg::SQRT_STAGES;

    logic [N-1:0]                valid_reg;
    logic [N:0]                  rdy;
    logic [pgm_pkg::RAD_W-1:0]   rad_reg  [N];
    logic [pgm_pkg::REM_W-1:0]   rem_reg  [N];
    logic [pgm_pkg::MAG_W-1:0]   root_reg [N];
    pgm_pkg::pgm_tag_t           tag_reg  [N];

    assign rdy[N]   = out_ready;
    assign in_ready = rdy[0];

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        logic                        src_valid;
        logic [pgm_pkg::RAD_W-1:0]   src_rad;
        logic [pgm_pkg::REM_W-1:0]   src_rem;
        logic [pgm_pkg::MAG_W-1:0]   src_root;
        pgm_pkg::pgm_tag_t           src_tag;
        logic [pgm_pkg::REM_W+1:0]   wide;
        logic [pgm_pkg::REM_W+1:0]   trial;
        logic [pgm_pkg::REM_W+1:0]   diff;
        logic                        ge;

        if (i == 0)
        begin : g_first
            assign src_valid = in_valid;
            assign src_rad   = in_rad;
            assign src_rem   = '0;
            assign src_root  = '0;
            assign src_tag   = in_tag;
        end
        else
        begin : g_next
            assign src_valid = valid_reg[i-1];
            assign src_rad   = rad_reg[i-1];
            assign src_rem   = rem_reg[i-1];
            assign src_root  = root_reg[i-1];
            assign src_tag   = tag_reg[i-1];
        end

        // Bring down the next two radicand bits and try 4*root + 1.
        assign wide  = {src_rem, src_rad[pgm_pkg::RAD_W-1 -: 2]};
        assign trial = (pgm_pkg::REM_W+2)'({src_root, 2'b01});
        assign diff  = wide - trial;
        assign ge    = (wide >= trial);

        assign rdy[i] = !valid_reg[i] || rdy[i+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (rdy[i])
            begin
                valid_reg[i] <= src_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[i] && src_valid)
            begin
                rad_reg[i]  <= {src_rad[pgm_pkg::RAD_W-3:0], 2'b00};
                rem_reg[i]  <= ge ? diff[pgm_pkg::REM_W-1:0] : wide[pgm_pkg::REM_W-1:0];
                root_reg[i] <= {src_root[pgm_pkg::MAG_W-2:0], ge};
                tag_reg[i]  <= src_tag;
            end
        end
    end

    assign out_valid = valid_reg[N-1];
    assign out_root  = root_reg[N-1];
    assign out_tag   = tag_reg[N-1];

endmodule

@@ sv/prewitt_gradient_magnitude_unit.sv @@
// ============================================================================
// prewitt_gradient_magnitude_unit: 3x3 Prewitt edge magnitude on a pixel stream
// Line memory, sliding window, gradient sums, squares and a pipelined square
// root, producing one saturated magnitude per full window.
// ============================================================================
// Pipeline: a result passes memory read, window, gradients, squares, sum and
// 8 root stages after the pixel that completes its window is accepted.
// Throughput: one pixel per clock; the single-port-write, single-read line
// memory is read and written once per pixel; only a stalled m_tready slows it.
// Reset: counters and window clear, both size registers go to 512. The line
// memory is not cleared; rows are always written before a result uses them.
// ============================================================================
module prewitt_gradient_magnitude_unit
(
    input  logic                            clk,
    input  logic                            rst_n,

    // Pixel input stream.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] red_sample
    input  logic                            s_tuser,   // [0] frame_start

    // Result output stream.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [31:0]                     m_tdata,   // [7:0] magnitude,
                                                       // [18:8] window_column,
                                                       // [29:19] window_row,
                                                       // [31:30] zero
    output logic                            m_tlast,   // frame_last

    // Configuration write port.
    input  logic                            cfg_we,
    input  logic [pgm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pgm_pkg::CFG_W-1:0]       cfg_data
);

    localparam int CW = pgm_pkg::CFG_W;
    localparam int LW = 2 * pgm_pkg::PIX_W;

    // ------------------------------------------------------------------
    // Configuration registers and their clamped effective values.
    // ------------------------------------------------------------------
    logic [CW-1:0] image_width_reg;
    logic [CW-1:0] image_height_reg;
    logic [CW-1:0] width_eff;
    logic [CW-1:0] height_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= CW'(512);
            image_height_reg <= CW'(512);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pgm_pkg::CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                pgm_pkg::CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
            endcase
        end
    end

    always_comb
    begin
        priority if (image_width_reg < CW'(3))
            width_eff = CW'(3);
        else if (image_width_reg > CW'(pgm_pkg::MAX_WIDTH))
            width_eff = CW'(pgm_pkg::MAX_WIDTH);
        else
            width_eff = image_width_reg;

        priority if (image_height_reg < CW'(3))
            height_eff = CW'(3);
        else if (image_height_reg > CW'(pgm_pkg::MAX_HEIGHT))
            height_eff = CW'(pgm_pkg::MAX_HEIGHT);
        else
            height_eff = image_height_reg;
    end

    // ------------------------------------------------------------------
    // Position counters. The position of an incoming pixel is settled at
    // accept time: frame_start forces the origin, and a counter that sits
    // at or past the frame size (after a size change) wraps right away.
    // ------------------------------------------------------------------
    logic [pgm_pkg::COL_W-1:0] col_reg;
    logic [pgm_pkg::ROW_W-1:0] row_reg;
    logic [CW-1:0]             cur_col;
    logic [CW-1:0]             cur_row;
    logic [CW-1:0]             col_next;
    logic [CW-1:0]             row_next;
    logic                      cur_emit;
    logic                      cur_last;
    logic                      accept;

    always_comb
    begin
        cur_col = s_tuser ? '0 : CW'(col_reg);
        cur_row = s_tuser ? '0 : CW'(row_reg);
        if (cur_col >= width_eff)
        begin
            cur_col = '0;
            cur_row = cur_row + CW'(1);
        end
        if (cur_row >= height_eff)
        begin
            cur_row = '0;
        end

        col_next = cur_col + CW'(1);
        row_next = cur_row;
        if (col_next >= width_eff)
        begin
            col_next = '0;
            row_next = cur_row + CW'(1);
            if (row_next >= height_eff)
            begin
                row_next = '0;
            end
        end

        cur_emit = (cur_col >= CW'(2)) && (cur_row >= CW'(2));
        cur_last = (cur_col == width_eff - CW'(1)) && (cur_row == height_eff - CW'(1));
    end

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next[pgm_pkg::COL_W-1:0];
            row_reg <= row_next[pgm_pkg::ROW_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Line memory. One entry per column holds the pixel of the row above
    // in the low byte and the pixel two rows above in the high byte. The
    // entry is read when a pixel is accepted and written back when that
    // pixel leaves stage 1.
    // ------------------------------------------------------------------
    logic [LW-1:0]             line_mem [pgm_pkg::MAX_WIDTH];
    logic [LW-1:0]             rd_data_reg;
    logic [LW-1:0]             fwd_data_reg;
    logic                      fwd_reg;
    logic [LW-1:0]             line_s1;
    logic [LW-1:0]             wr_data;

    // Stage 1: the pixel whose line entry is being read.
    logic                      s1_valid_reg;
    logic [pgm_pkg::PIX_W-1:0] s1_px_reg;
    logic [pgm_pkg::COL_W-1:0] s1_col_reg;
    logic [pgm_pkg::ROW_W-1:0] s1_row_reg;
    logic                      s1_emit_reg;
    logic                      s1_last_reg;
    logic                      s1_fire;
    logic                      s1_ready;

    // A pixel that lands on the column just being written back would read
    // the old entry, so the written data is forwarded instead.
    assign line_s1 = fwd_reg ? fwd_data_reg : rd_data_reg;
    assign wr_data = {line_s1[pgm_pkg::PIX_W-1:0], s1_px_reg};

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            line_mem[s1_col_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg <= line_mem[cur_col[pgm_pkg::COL_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (accept)
        begin
            fwd_reg <= s1_fire && (s1_col_reg == cur_col[pgm_pkg::COL_W-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fwd_data_reg <= wr_data;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline handshake. Each stage moves when the one after it has room.
    // Stage 1 may only shift the window when stage 2 is free, because the
    // window is the payload of stage 2.
    // ------------------------------------------------------------------
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic s4_valid_reg;
    logic s5_valid_reg;
    logic s2_ready;
    logic s3_ready;
    logic s4_ready;
    logic s5_ready;
    logic root_in_ready;

    assign s5_ready = !s5_valid_reg || root_in_ready;
    assign s4_ready = !s4_valid_reg || s5_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_fire  = s1_valid_reg && s2_ready;
    assign s1_ready = !s1_valid_reg || s1_fire;
    assign s_tready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_px_reg   <= s_tdata[pgm_pkg::PIX_W-1:0];
            s1_col_reg  <= cur_col[pgm_pkg::COL_W-1:0];
            s1_row_reg  <= cur_row[pgm_pkg::ROW_W-1:0];
            s1_emit_reg <= cur_emit;
            s1_last_reg <= cur_last;
        end
    end

    // ------------------------------------------------------------------
    // 3x3 window, entry r*3+c with row 0 on top and column 2 newest.
    // ------------------------------------------------------------------
    logic [8:0][pgm_pkg::PIX_W-1:0] win_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (s1_fire)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r*3]     <= win_reg[r*3 + 1];
                win_reg[r*3 + 1] <= win_reg[r*3 + 2];
            end
            win_reg[2] <= line_s1[LW-1:pgm_pkg::PIX_W];
            win_reg[5] <= line_s1[pgm_pkg::PIX_W-1:0];
            win_reg[8] <= s1_px_reg;
        end
    end

    // Stage 2: the window holds a full neighborhood; only pixels that
    // complete a window enter this stage.
    pgm_pkg::pgm_tag_t s2_tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg && s1_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            s2_tag_reg.sat  <= 1'b0;
            s2_tag_reg.col  <= pgm_pkg::POS_W'(s1_col_reg - pgm_pkg::COL_W'(2));
            s2_tag_reg.row  <= pgm_pkg::POS_W'(s1_row_reg - pgm_pkg::ROW_W'(2));
            s2_tag_reg.last <= s1_last_reg;
        end
    end

    // Column and row sums with equal weights.
    logic [9:0]         sum_left;
    logic [9:0]         sum_right;
    logic [9:0]         sum_top;
    logic [9:0]         sum_bottom;
    logic signed [10:0] gx_next;
    logic signed [10:0] gy_next;

    assign sum_left   = 10'(win_reg[0]) + 10'(win_reg[3]) + 10'(win_reg[6]);
    assign sum_right  = 10'(win_reg[2]) + 10'(win_reg[5]) + 10'(win_reg[8]);
    assign sum_top    = 10'(win_reg[0]) + 10'(win_reg[1]) + 10'(win_reg[2]);
    assign sum_bottom = 10'(win_reg[6]) + 10'(win_reg[7]) + 10'(win_reg[8]);
    assign gx_next    = $signed({1'b0, sum_right})  - $signed({1'b0, sum_left});
    assign gy_next    = $signed({1'b0, sum_bottom}) - $signed({1'b0, sum_top});

    // Stage 3: gradients.
    logic signed [10:0] gx_reg;
    logic signed [10:0] gy_reg;
    pgm_pkg::pgm_tag_t  s3_tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (s3_ready)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && s2_valid_reg)
        begin
            gx_reg     <= gx_next;
            gy_reg     <= gy_next;
            s3_tag_reg <= s2_tag_reg;
        end
    end

    // Stage 4: squares. Each magnitude is at most 765, so a square fits
    // in 20 bits.
    logic signed [21:0] gx_sq;
    logic signed [21:0] gy_sq;
    logic [19:0]        sqx_reg;
    logic [19:0]        sqy_reg;
    pgm_pkg::pgm_tag_t  s4_tag_reg;

    assign gx_sq = gx_reg * gx_reg;
    assign gy_sq = gy_reg * gy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else if (s4_ready)
        begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s4_ready && s3_valid_reg)
        begin
            sqx_reg    <= gx_sq[19:0];
            sqy_reg    <= gy_sq[19:0];
            s4_tag_reg <= s3_tag_reg;
        end
    end

    // Stage 5: energy. Anything at or above 2^16 has a root above 255 and
    // saturates, so only the low 16 bits go through the root pipeline.
    logic [20:0]                energy;
    logic [pgm_pkg::RAD_W-1:0]  rad_reg;
    pgm_pkg::pgm_tag_t          s5_tag_reg;

    assign energy = 21'(sqx_reg) + 21'(sqy_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
        end
        else if (s5_ready)
        begin
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s5_ready && s4_valid_reg)
        begin
            rad_reg    <= energy[pgm_pkg::RAD_W-1:0];
            s5_tag_reg <= {|energy[20:pgm_pkg::RAD_W], s4_tag_reg.col,
                           s4_tag_reg.row, s4_tag_reg.last};
        end
    end

    // ------------------------------------------------------------------
    // Square root; its last stage is the output register.
    // ------------------------------------------------------------------
    logic [pgm_pkg::MAG_W-1:0] root;
    pgm_pkg::pgm_tag_t         out_tag;

    pgm_isqrt u_isqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s5_valid_reg),
        .in_ready  (root_in_ready),
        .in_rad    (rad_reg),
        .in_tag    (s5_tag_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_root  (root),
        .out_tag   (out_tag)
    );

    assign m_tdata = {2'b00, out_tag.row, out_tag.col,
                      (out_tag.sat ? {pgm_pkg::MAG_W{1'b1}} : root)};
    assign m_tlast = out_tag.last;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // While the window item waits for stage 3, the window must not shift.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !s3_ready) |=> $stable(win_reg))
    else $error("window shifted under a held gradient item");

    // A pixel held in stage 1 blocks new input.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_ready) |-> !s_tready)
    else $error("input accepted while stage 1 is blocked");

    // Forwarding is armed only by a write-back that coincided with a read.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(fwd_reg) |-> $past(s1_fire && accept))
    else $error("line forwarding armed without a concurrent write-back");

endmodule
